[rtl/scc_pkg.sv]
package scc_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned AddrW = 5;

  localparam logic [AddrW-1:0] RegPosX  = 5'd0;
  localparam logic [AddrW-1:0] RegPosY  = 5'd4;
  localparam logic [AddrW-1:0] RegVelX  = 5'd8;
  localparam logic [AddrW-1:0] RegVelY  = 5'd12;
  localparam logic [AddrW-1:0] RegSizeX = 5'd16;
  localparam logic [AddrW-1:0] RegSizeY = 5'd20;

  localparam logic [2:0] StyleFloor      = 3'd0;
  localparam logic [2:0] StylePlateFloor = 3'd1;
  localparam logic [2:0] StyleCeil       = 3'd2;
  localparam logic [2:0] StylePlateCeil  = 3'd3;
  localparam logic [2:0] StyleOther      = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture segment word
    logic div_start;  // start a division
    logic div_sel;    // 0: segment slope, 1: velocity slope
    logic div_step;   // one quotient bit
    logic div_done;   // write quotient back
    logic mul_a;      // slope * left x
    logic mul_b;      // slope * pos x
    logic decide;     // run the tests and latch
    logic clear;      // scan end clear
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

[rtl/segment_contact_classifier_unit.sv]
// Segment contact classifier.
// A segment word is taken in idle only; it runs the bit-serial restoring divider
// twice (segment slope, velocity slope), then two multiplies and the tests, on
// Q16.16 values by default. A result word follows the last segment of a scan;
// it waits in place until taken, and the next segment is accepted once it leaves.
// Reset: rst_ni (async, low) clears the registers, contact flags and control.
module segment_contact_classifier_unit #(
  parameter int unsigned FracBits = scc_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        seg_start_x_i,
  input  logic signed [31:0]        seg_start_y_i,
  input  logic signed [31:0]        seg_end_x_i,
  input  logic signed [31:0]        seg_end_y_i,
  input  logic [2:0]                seg_style_i,
  input  logic                      scan_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_below_o,
  output logic                      hit_above_o,
  output logic                      hit_left_o,
  output logic                      hit_right_o,
  output logic signed [31:0]        floor_slope_o,
  output logic signed [31:0]        floor_offset_o
);
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic [30:0] size_x_q, size_y_q;
  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  assign pready = 1'b1;

  // register file write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0; pos_y_q <= '0; vel_x_q <= '0; vel_y_q <= '0;
      size_x_q <= '0; size_y_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        scc_pkg::RegPosX:  pos_x_q <= pwdata;
        scc_pkg::RegPosY:  pos_y_q <= pwdata;
        scc_pkg::RegVelX:  vel_x_q <= pwdata;
        scc_pkg::RegVelY:  vel_y_q <= pwdata;
        scc_pkg::RegSizeX: size_x_q <= pwdata[30:0];
        scc_pkg::RegSizeY: size_y_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      scc_pkg::RegPosX:  prdata = pos_x_q;
      scc_pkg::RegPosY:  prdata = pos_y_q;
      scc_pkg::RegVelX:  prdata = vel_x_q;
      scc_pkg::RegVelY:  prdata = vel_y_q;
      scc_pkg::RegSizeX: prdata = {1'b0, size_x_q};
      scc_pkg::RegSizeY: prdata = {1'b0, size_y_q};
      default:           prdata = '0;
    endcase
  end

  scc_ctrl #(.FracBits(FracBits)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  scc_datapath #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pos_x_i(pos_x_q), .pos_y_i(pos_y_q), .vel_x_i(vel_x_q), .vel_y_i(vel_y_q),
    .size_x_i(size_x_q), .size_y_i(size_y_q),
    .seg_start_x_i, .seg_start_y_i, .seg_end_x_i, .seg_end_y_i,
    .seg_style_i, .scan_last_i,
    .hit_below_o, .hit_above_o, .hit_left_o, .hit_right_o,
    .floor_slope_o, .floor_offset_o
  );
endmodule

[rtl/scc_ctrl.sv]
module scc_ctrl #(
  parameter int unsigned FracBits = scc_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  scc_pkg::sts_t sts_i,
  output scc_pkg::cmd_t cmd_o
);
  localparam int unsigned QBits = 32 + FracBits + 1;
  localparam int unsigned CntW = $clog2(QBits + 1);

  typedef enum logic [3:0] {
    StIdle, StDivA, StRunA, StEndA, StDivB, StRunB, StEndB, StMulA, StMulB,
    StDecide, StOut
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic out_valid_q;

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle:   cmd_o.load = in_valid_i;
      StDivA:   cmd_o.div_start = 1'b1;
      StRunA:   cmd_o.div_step = 1'b1;
      StEndA:   cmd_o.div_done = 1'b1;
      StDivB:   begin cmd_o.div_start = 1'b1; cmd_o.div_sel = 1'b1; end
      StRunB:   begin cmd_o.div_step = 1'b1; cmd_o.div_sel = 1'b1; end
      StEndB:   begin cmd_o.div_done = 1'b1; cmd_o.div_sel = 1'b1; end
      StMulA:   cmd_o.mul_a = 1'b1;
      StMulB:   cmd_o.mul_b = 1'b1;
      StDecide: cmd_o.decide = 1'b1;
      StOut:    cmd_o.clear = !out_stall_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StDivA;
        StDivA: begin cnt_q <= CntW'(QBits); state_q <= StRunA; end
        StRunA: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) state_q <= StEndA;
        end
        StEndA: state_q <= StDivB;
        StDivB: begin cnt_q <= CntW'(QBits); state_q <= StRunB; end
        StRunB: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) state_q <= StEndB;
        end
        StEndB: state_q <= StMulA;
        StMulA: state_q <= StMulB;
        StMulB: state_q <= StDecide;
        StDecide: begin
          if (sts_i.last) begin
            state_q <= StOut;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: if (!out_stall_i) begin
          out_valid_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[rtl/scc_datapath.sv]
module scc_datapath #(
  parameter int unsigned FracBits = scc_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::cmd_t      cmd_i,
  output scc_pkg::sts_t      sts_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [30:0]        size_x_i,
  input  logic [30:0]        size_y_i,
  input  logic signed [31:0] seg_start_x_i,
  input  logic signed [31:0] seg_start_y_i,
  input  logic signed [31:0] seg_end_x_i,
  input  logic signed [31:0] seg_end_y_i,
  input  logic [2:0]         seg_style_i,
  input  logic               scan_last_i,
  output logic               hit_below_o,
  output logic               hit_above_o,
  output logic               hit_left_o,
  output logic               hit_right_o,
  output logic signed [31:0] floor_slope_o,
  output logic signed [31:0] floor_offset_o
);
  // numerator magnitude holds 33 bits shifted by FracBits
  localparam int unsigned NW = 33 + FracBits;
  localparam int unsigned PW = 64;
  localparam logic signed [PW-1:0] SMax = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0] SMin = -PW'(64'sh8000_0000);

  logic signed [32:0] ax_q, ay_q, bx_q, by_q;
  logic [2:0] style_q;
  logic last_q;

  logic signed [33:0] dx, dy;
  logic a_lt_b;
  logic signed [32:0] lx, ly, rx, ry;
  assign a_lt_b = ax_q < bx_q;
  assign lx = a_lt_b ? ax_q : bx_q;
  assign ly = a_lt_b ? ay_q : by_q;
  assign rx = a_lt_b ? bx_q : ax_q;
  assign ry = a_lt_b ? by_q : ay_q;
  assign dx = 34'(rx) - 34'(lx);
  assign dy = 34'(ry) - 34'(ly);

  // restoring divider over magnitudes
  logic [NW-1:0] num_q, quo_q;
  logic [33:0] den_q;
  logic [34:0] rem_q;
  logic neg_q;
  logic signed [PW-1:0] slope_q, vslope_q;
  logic [34:0] trial;
  logic [NW-1:0] magq;
  logic signed [PW-1:0] sq;

  logic signed [33:0] num_s;
  logic [33:0] den_s;
  always_comb begin
    if (cmd_i.div_sel) begin
      num_s = 34'(vel_y_i);
      den_s = vel_x_i[31] ? 34'(-34'(vel_x_i)) : 34'(vel_x_i);
    end else begin
      num_s = dy;
      den_s = 34'(dx);
    end
  end

  assign trial = {rem_q[33:0], num_q[NW-1]} - {1'b0, den_q};
  always_comb begin
    magq = quo_q;
    if (|magq[NW-1:31]) sq = neg_q ? SMin : SMax;
    else sq = neg_q ? -PW'(magq) : PW'(magq);
    if (!neg_q && magq[NW-1:31] == '0) sq = PW'(magq);
  end

  // products for offset and height
  logic signed [PW-1:0] prod_q, offset_q;
  logic signed [PW-1:0] mp, fl, ofs;
  logic signed [32:0] mul_op;
  assign mul_op = cmd_i.mul_a ? lx : 33'(pos_x_i);
  assign mp = PW'($signed(slope_q[31:0])) * PW'(mul_op);
  assign fl = prod_q >>> FracBits;
  assign ofs = PW'(ly) - fl;

  logic seen_b_q, seen_a_q, seen_l_q, seen_r_q;
  logic signed [31:0] kslope_q, koffset_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= 33'(seg_start_x_i); ay_q <= 33'(seg_start_y_i);
      bx_q <= 33'(seg_end_x_i);   by_q <= 33'(seg_end_y_i);
      style_q <= seg_style_i;     last_q <= scan_last_i;
    end
    if (cmd_i.div_start) begin
      neg_q <= num_s[33];
      num_q <= NW'(num_s[33] ? 34'(-num_s) : num_s) << FracBits;
      den_q <= (den_s == '0) ? 34'd1 : den_s;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (!trial[34]) begin
        rem_q <= trial; quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[33:0], num_q[NW-1]}; quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_done) begin
      if (!cmd_i.div_sel) slope_q <= sq;
      else vslope_q <= (vel_x_i == '0) ? PW'(vel_y_i) : sq;
    end
    if (cmd_i.mul_a || cmd_i.mul_b) prod_q <= mp;
    if (cmd_i.mul_b) begin
      offset_q <= (ofs > SMax) ? SMax : ((ofs < SMin) ? SMin : ofs);
    end
  end

  // tests, using the registered product of slope * pos x
  logic signed [PW-1:0] hgt, py, sx, reach, top, bot;
  logic flo, cei, vert, cov, wall;
  always_comb begin
    hgt = fl + offset_q;
    py = PW'(pos_y_i);
    sx = PW'(size_x_i);
    reach = (size_x_i > size_y_i) ? PW'(size_x_i) : PW'(size_y_i);
    top = (ay_q < by_q) ? PW'(by_q) : PW'(ay_q);
    bot = (ay_q < by_q) ? PW'(ay_q) : PW'(by_q);
    flo = (style_q == scc_pkg::StyleFloor) || (style_q == scc_pkg::StylePlateFloor);
    cei = (style_q == scc_pkg::StyleCeil) || (style_q == scc_pkg::StylePlateCeil);
    vert = (lx == rx);
    cov = !(33'(pos_x_i) < lx) && !(33'(pos_x_i) > rx);
    wall = !(py > top) && !(py + reach < bot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_b_q <= 1'b0; seen_a_q <= 1'b0; seen_l_q <= 1'b0; seen_r_q <= 1'b0;
      kslope_q <= '0; koffset_q <= '0;
    end else if (cmd_i.clear) begin
      seen_b_q <= 1'b0; seen_a_q <= 1'b0; seen_l_q <= 1'b0; seen_r_q <= 1'b0;
      kslope_q <= '0; koffset_q <= '0;
    end else if (cmd_i.decide) begin
      if (!vert && cov) begin
        if (flo && !seen_b_q && vslope_q <= slope_q && py - sx <= hgt && py >= hgt) begin
          seen_b_q <= 1'b1;
          kslope_q <= slope_q[31:0];
          koffset_q <= offset_q[31:0];
        end else if (cei && !seen_a_q && py + reach >= hgt && py <= hgt) begin
          seen_a_q <= 1'b1;
        end
      end else if (vert && wall) begin
        if (cei && !seen_l_q && PW'(pos_x_i) - sx < PW'(lx) && PW'(pos_x_i) >= PW'(lx)) begin
          seen_l_q <= 1'b1;
        end else if (flo && !seen_r_q && PW'(pos_x_i) + sx > PW'(lx) &&
                     PW'(pos_x_i) <= PW'(lx)) begin
          seen_r_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.last = last_q;
  assign hit_below_o = seen_b_q;
  assign hit_above_o = seen_a_q;
  assign hit_left_o = seen_l_q;
  assign hit_right_o = seen_r_q;
  assign floor_slope_o = kslope_q;
  assign floor_offset_o = koffset_q;
endmodule

[sim/tb_top.sv]
module tb_top;

  localparam int Frac = scc_pkg::FracBitsDefault;
  localparam int SettleCycles = 150;  // covers one segment word

  // one segment word as offered to the block
  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic [2:0]         style;
    logic               last;
  } seg_t;

  // one scan result word
  typedef struct {
    logic               below, above, left, right;
    logic signed [31:0] slope, offset;
  } hits_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // APB side, owned by the main initial block
  logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [scc_pkg::AddrW-1:0] paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // segment side, owned by the driver
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
  logic [2:0]         seg_style = '0;
  logic               seg_last = 1'b0;

  // result side
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hb, ha, hl, hr;
  logic signed [31:0] fslope, foffset;

  segment_contact_classifier_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .seg_start_x_i(seg_sx), .seg_start_y_i(seg_sy),
    .seg_end_x_i(seg_ex), .seg_end_y_i(seg_ey),
    .seg_style_i(seg_style), .scan_last_i(seg_last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_below_o(hb), .hit_above_o(ha), .hit_left_o(hl), .hit_right_o(hr),
    .floor_slope_o(fslope), .floor_offset_o(foffset)
  );

  seg_t  pend_q[$];     // words waiting to be offered
  hits_t hits_q[$];     // scan results still owed by the block
  int    errors = 0;
  int    idle_mode = 0; // 0: sender 26% / receiver 78%, 1: swapped, 2: none
  bit    hold_go = 1'b0;
  int    hold_cnt = 0;
  bit    took = 1'b0;   // word accepted at the last rising edge

  // body registers and contact state of the predictor
  longint bx, by, bvx, bvy, bsx, bsy;
  bit     sb, sa, sl, sr;
  longint k_slope, k_offset;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // (num << Frac) / den with den > 0, truncated toward zero, saturated to 32 bits
  function automatic longint fix_div(longint num, longint den);
    return sat32((num * (64'sd1 <<< Frac)) / den);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    return 32'(sat32(v));
  endfunction

  // contact tests for one segment, updating the latched flags
  task automatic classify_seg(seg_t s);
    longint ax, ay, ex, ey, lx, ly, rx, ry, reach, slope, offset, height, vslope;
    longint ytop, ybot;
    bit flo, cei;
    ax = s.sx; ay = s.sy; ex = s.ex; ey = s.ey;
    flo = (s.style == scc_pkg::StyleFloor) || (s.style == scc_pkg::StylePlateFloor);
    cei = (s.style == scc_pkg::StyleCeil) || (s.style == scc_pkg::StylePlateCeil);
    reach = (bsx > bsy) ? bsx : bsy;
    if (ax < ex) begin
      lx = ax; ly = ay; rx = ex; ry = ey;
    end else begin
      lx = ex; ly = ey; rx = ax; ry = ay;
    end
    if (lx != rx) begin
      if (bx < lx || bx > rx) return;
      slope  = fix_div(ry - ly, rx - lx);
      offset = sat32(ly - ((slope * lx) >>> Frac));
      height = ((slope * bx) >>> Frac) + offset;
      vslope = (bvx != 0) ? fix_div(bvy, (bvx < 0) ? -bvx : bvx) : bvy;
      if (flo && !sb && vslope <= slope && by - bsx <= height && by >= height) begin
        sb = 1'b1;
        k_slope = slope;
        k_offset = offset;
        return;
      end
      if (cei && !sa && by + reach >= height && by <= height) sa = 1'b1;
      return;
    end
    ytop = (ay < ey) ? ey : ay;
    ybot = (ay < ey) ? ay : ey;
    if (by > ytop || by + reach < ybot) return;
    if (cei && !sl && bx - bsx < lx && bx >= lx) begin
      sl = 1'b1;
      return;
    end
    if (flo && !sr && bx + bsx > lx && bx <= lx) sr = 1'b1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // rising edge: check results, then predict for an accepted word
  always @(posedge clk) begin
    hits_t w;
    seg_t  s;
    if (out_valid && !out_stall) begin
      if (hits_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = hits_q.pop_front();
        if (hb !== w.below) report_mismatch("hit_below", hb, w.below);
        if (ha !== w.above) report_mismatch("hit_above", ha, w.above);
        if (hl !== w.left) report_mismatch("hit_left", hl, w.left);
        if (hr !== w.right) report_mismatch("hit_right", hr, w.right);
        if (fslope !== w.slope) report_mismatch("floor_slope", fslope, w.slope);
        if (foffset !== w.offset) report_mismatch("floor_offset", foffset, w.offset);
      end
    end
    if (in_valid && !in_stall && rst_n) begin
      took = 1'b1;
      s.sx = seg_sx; s.sy = seg_sy; s.ex = seg_ex; s.ey = seg_ey;
      s.style = seg_style; s.last = seg_last;
      classify_seg(s);
      if (s.last) begin
        w.below = sb; w.above = sa; w.left = sl; w.right = sr;
        w.slope = 32'(k_slope); w.offset = 32'(k_offset);
        hits_q.push_back(w);
        sb = 0; sa = 0; sl = 0; sr = 0;
        k_slope = 0; k_offset = 0;
      end
    end
  end

  // driver: a valid word stays up until taken
  always @(negedge clk) begin
    seg_t s;
    int   idle_pct;
    if (rst_n && (!in_valid || took)) begin
      idle_pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 78 : 0;
      if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s = pend_q.pop_front();
        in_valid  <= 1'b1;
        seg_sx    <= s.sx; seg_sy <= s.sy; seg_ex <= s.ex; seg_ey <= s.ey;
        seg_style <= s.style;
        seg_last  <= s.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    took = 1'b0;
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_mode == 0) ? 78 : (idle_mode == 1) ? 26 : 0;
    if (hold_go && hold_cnt < 400) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic apb_write(logic [scc_pkg::AddrW-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_body(logic signed [31:0] px, py, vx, vy, logic [30:0] szx, szy);
    apb_write(scc_pkg::RegPosX, px);
    apb_write(scc_pkg::RegPosY, py);
    apb_write(scc_pkg::RegVelX, vx);
    apb_write(scc_pkg::RegVelY, vy);
    apb_write(scc_pkg::RegSizeX, {1'b0, szx});
    apb_write(scc_pkg::RegSizeY, {1'b0, szy});
    bx = px; by = py; bvx = vx; bvy = vy; bsx = szx; bsy = szy;
  endtask

  // nothing queued or offered, no result owed and the block back at rest
  task automatic wait_drained();
    do @(posedge clk);
    while (pend_q.size() != 0 || in_valid || hits_q.size() != 0 || in_stall);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic seg_t mk(longint ax, ay, ex, ey, int st, bit lst);
    seg_t s;
    s.sx = clip32(ax); s.sy = clip32(ay); s.ex = clip32(ex); s.ey = clip32(ey);
    s.style = st[2:0];
    s.last = lst;
    return s;
  endfunction

  // a segment placed around the body, so that the tests can pass
  function automatic seg_t near_seg(bit lst);
    longint d1, d2, y0, tilt, x0;
    int     st;
    seg_t   s;
    d1 = $urandom_range(1 << 20);
    d2 = $urandom_range(1 << 20);
    tilt = $signed($urandom_range(1 << 17)) - (1 << 16);
    st = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(3);
    case ($urandom_range(2))
      0: begin  // floor-like, just below the body
        y0 = by - $urandom_range(1 << 18);
        s = mk(bx - d1, y0 + tilt, bx + d2, y0 - tilt, st, lst);
      end
      1: begin  // ceiling-like, just above
        y0 = by + $urandom_range(1 << 18);
        s = mk(bx - d1, y0 - tilt, bx + d2, y0 + tilt, st, lst);
      end
      default: begin  // wall
        x0 = bx + $signed($urandom_range(1 << 19)) - (1 << 18);
        s = mk(x0, by - d1, x0, by + d2, st, lst);
      end
    endcase
    if ($urandom_range(1)) s = mk(s.ex, s.ey, s.sx, s.sy, s.style, lst);
    return s;
  endfunction

  function automatic seg_t noise_seg(bit lst);
    seg_t s;
    s.sx = $urandom; s.sy = $urandom; s.ex = $urandom; s.ey = $urandom;
    s.style = $urandom_range(7);
    s.last = lst;
    return s;
  endfunction

  task automatic queue_scans(int n);
    int len;
    while (n > 0) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 85) pend_q.push_back(near_seg(i == len - 1));
        else pend_q.push_back(noise_seg(i == len - 1));
      end
      n -= len;
    end
  endtask

  initial begin
    longint u;
    bx = 0; by = 0; bvx = 0; bvy = 0; bsx = 0; bsy = 0;
    sb = 0; sa = 0; sl = 0; sr = 0; k_slope = 0; k_offset = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: body at the origin, falling, 4 wide and 8 tall
    u = 64'sd1 <<< Frac;
    set_body(0, 0, 0, -u, 31'(4 * u), 31'(8 * u));
    pend_q.push_back(mk(-10 * u, -u, 10 * u, -u, scc_pkg::StyleFloor, 0));      // flat floor
    pend_q.push_back(mk(10 * u, 2 * u, -10 * u, 2 * u, scc_pkg::StyleCeil, 0)); // ceiling
    pend_q.push_back(mk(-2 * u, -u, -2 * u, 3 * u, scc_pkg::StyleCeil, 0));     // left wall
    pend_q.push_back(mk(2 * u, 3 * u, 2 * u, -u, scc_pkg::StyleFloor, 1));      // right wall
    pend_q.push_back(mk(0, -u, 0, 3 * u, scc_pkg::StyleFloor, 0));   // vertical at body x
    pend_q.push_back(mk(-u, -u, u, -u, scc_pkg::StyleOther, 0));     // unknown style
    pend_q.push_back(mk(-u, -u, u, -u, 7, 1));                       // scan with no floor
    pend_q.push_back(mk(-u, -3 * u, u, u, scc_pkg::StylePlateFloor, 0)); // plate floor, tilted
    pend_q.push_back(mk(-u, u, u, u, scc_pkg::StylePlateCeil, 0));
    pend_q.push_back(mk(-1, -64'sd2147483648, 1, 64'sd2147483647,
                        scc_pkg::StyleFloor, 1));                    // saturation
    pend_q.push_back(mk(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                        -64'sd2147483648, scc_pkg::StyleFloor, 0));  // field extremes
    pend_q.push_back(mk(64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
                        64'sd2147483647, scc_pkg::StyleCeil, 1));
    pend_q.push_back(mk(0, 0, 0, 0, scc_pkg::StyleFloor, 1));        // point segment
    wait_drained();

    // extreme bodies, then random ones
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph / 2;
      case (ph)
        0: set_body(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                    31'h7FFFFFFF, 31'h0);
        1: set_body(32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh80000000,
                    31'h0, 31'h7FFFFFFF);
        default: set_body($urandom_range(1 << 26) - (1 << 25), $urandom_range(1 << 26) - (1 << 25),
                          $urandom, ($urandom_range(3) == 0) ? 0 : $urandom,
                          $urandom_range(1 << 20), $urandom_range(1 << 20));
      endcase
      if (ph == 2) hold_go = 1'b1;
      queue_scans(ph < 2 ? 100 : 360);
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
